// ===== hdl/mrnw_pkg.sv =====
package mrnw_pkg;

  localparam int SEQ_W     = 31;
  localparam int ORIGIN_W  = 8;
  localparam int PAYLOAD_W = 20;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = ORIGIN_W + PAYLOAD_W;
  localparam int WINDOW_DEFAULT = 32;

  localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUFFERED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd3;

  // Classification of a transfer, computed by the datapath.
  typedef enum logic [2:0] {
    CLS_ECHO    = 3'b001,
    CLS_INORDER = 3'b010,
    CLS_AHEAD   = 3'b100
  } cls_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;     // latch input transfer and classify it
    logic store_in;    // write input packet into its slot, clear its mark
    logic emit_first;  // load output register with the first result
    logic mark_step;   // mark one skipped slot, advance mark cursor
    logic mark_done;   // finish gap marking, update highest
    logic read_slot;   // read the slot at next_expected
    logic emit_drain;  // load output register with the read slot
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    cls_t cls;
    logic gap_needed;  // ahead packet above highest
    logic mark_last;   // marking cursor at final skipped slot
    logic gap_empty;   // no slots to mark
    logic drain_ok;    // next slot may be delivered
  } dp_sts_t;

endpackage

// ===== hdl/multicast_reorder_nack_window.sv =====
// Multicast reorder window with loss marks.
// Input channel: valid/stall with seq_number, origin_node, payload_value.
// Output channel: out_valid/out_stall with status, out_seq, out_origin,
// out_payload, last_of_run. One input transfer yields 1 to WINDOW output
// transfers; the final one carries last_of_run.
// Stale packets (below next expected) echo with status 2; packets at or
// beyond next expected + WINDOW echo with status 3; packets ahead buffer and
// echo with status 1, marking every skipped slot above the highest seen
// missing first; an in-order packet delivers with status 0 and then drains
// buffered successors in order until a missing slot, the highest seen, or
// WINDOW results.
// The first result is offered after classification, any marking of missing
// slots and the result load; each drained successor needs a slot read, then
// a result load, and the window is walked one slot at a time. stall is high
// while a transfer is in work, so a new input is taken only once the last
// result of the previous run has been queued.
// Results pass through a two-entry queue; a stalled receiver holds the walk
// once the queue is full, and nothing is lost.
// Reset clears next expected, highest seen and all missing marks; the store
// needs no clearing.
module multicast_reorder_nack_window #(
  parameter int WINDOW = mrnw_pkg::WINDOW_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  output logic                           stall,
  input  logic [mrnw_pkg::SEQ_W-1:0]     seq_number,
  input  logic [mrnw_pkg::ORIGIN_W-1:0]  origin_node,
  input  logic [mrnw_pkg::PAYLOAD_W-1:0] payload_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mrnw_pkg::STATUS_W-1:0]  status,
  output logic [mrnw_pkg::SEQ_W-1:0]     out_seq,
  output logic [mrnw_pkg::ORIGIN_W-1:0]  out_origin,
  output logic [mrnw_pkg::PAYLOAD_W-1:0] out_payload,
  output logic                           last_of_run
);
  import mrnw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    q_full, push, push_last;
  logic [STATUS_W-1:0]  d_status;
  logic [SEQ_W-1:0]     d_seq;
  logic [ORIGIN_W-1:0]  d_origin;
  logic [PAYLOAD_W-1:0] d_payload;

  // Controller: walk one transfer at a time, push each result once the
  // queue has room, and flag the last one of the run.
  mrnw_ctrl u_ctrl (
    .clk, .rst, .valid, .stall, .q_full, .push, .push_last, .sts, .cmd
  );

  // Datapath: window state, slot store, and the result register that
  // feeds the queue.
  mrnw_datapath #(.WINDOW(WINDOW)) u_dp (
    .clk, .rst, .seq_number, .origin_node, .payload_value,
    .cmd, .sts,
    .status(d_status), .out_seq(d_seq), .out_origin(d_origin),
    .out_payload(d_payload)
  );

  mrnw_outq #(.DEPTH(2)) u_q (
    .clk, .rst, .push,
    .w_status(d_status), .w_seq(d_seq), .w_origin(d_origin),
    .w_payload(d_payload), .w_last(push_last), .full(q_full),
    .out_valid, .out_stall, .status, .out_seq, .out_origin, .out_payload,
    .last_of_run
  );

endmodule

// ===== hdl/mrnw_datapath.sv =====
module mrnw_datapath #(
  parameter int WINDOW = mrnw_pkg::WINDOW_DEFAULT
) (
  input  logic                              clk,
  input  logic [mrnw_pkg::SEQ_W-1:0]        seq_number,
  input  logic [mrnw_pkg::ORIGIN_W-1:0]     origin_node,
  input  logic [mrnw_pkg::PAYLOAD_W-1:0]    payload_value,
  input  logic                              rst,
  input  mrnw_pkg::dp_cmd_t                 cmd,
  output mrnw_pkg::dp_sts_t                 sts,
  output logic [mrnw_pkg::STATUS_W-1:0]     status,
  output logic [mrnw_pkg::SEQ_W-1:0]        out_seq,
  output logic [mrnw_pkg::ORIGIN_W-1:0]     out_origin,
  output logic [mrnw_pkg::PAYLOAD_W-1:0]    out_payload
);
  import mrnw_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);

  logic [SEQ_W-1:0]     next_expected;
  logic [SEQ_W-1:0]     highest_plus_one;
  logic [IDX_W-1:0]     ne_slot;
  logic [WINDOW-1:0]    missing_marks;
  logic [WORD_W-1:0]    packet_store [WINDOW];
  logic [SEQ_W-1:0]     in_seq;
  logic [ORIGIN_W-1:0]  in_origin;
  logic [PAYLOAD_W-1:0] in_payload;
  logic [IDX_W-1:0]     in_slot;
  cls_t                 cls;
  logic [STATUS_W-1:0]  echo_status;
  logic                 gap_needed;
  logic [CNT_W-1:0]     mark_cnt;
  logic [CNT_W-1:0]     mark_end;
  logic [IDX_W-1:0]     mark_slot;
  logic [WORD_W-1:0]    rd_word;
  logic [SEQ_W-1:0]     rd_seq;
  logic [CNT_W-1:0]     run_cnt;

  logic [SEQ_W-1:0] d_in, hdist, ne_plus1;
  logic [IDX_W-1:0] ne_slot_plus1;

  // Slot of base + ofs, modulo WINDOW; ofs stays below 2*WINDOW.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(WINDOW)) sum = sum - (CNT_W+1)'(WINDOW);
    return IDX_W'(sum);
  endfunction

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] sl);
    return (sl == IDX_W'(WINDOW - 1)) ? '0 : sl + 1'b1;
  endfunction

  assign d_in     = seq_number - next_expected;
  assign hdist    = highest_plus_one - next_expected;
  assign ne_plus1 = next_expected + 1'b1;
  // Restart at slot 0 when the sequence wraps to 0.
  assign ne_slot_plus1 = (ne_plus1 == '0) ? '0 : slot_inc(ne_slot);

  // Classify and latch the transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_seq     <= seq_number;
      in_origin  <= origin_node;
      in_payload <= payload_value;
      in_slot    <= slot_add(ne_slot, CNT_W'(d_in));
      mark_slot  <= slot_add(ne_slot, CNT_W'(hdist));
      mark_cnt   <= CNT_W'(hdist);
      mark_end   <= CNT_W'(d_in);
      gap_needed <= (d_in >= hdist);
      if (seq_number < next_expected) begin
        cls <= CLS_ECHO;
        echo_status <= ST_STALE;
      end else if (d_in >= WIN_SEQ) begin
        cls <= CLS_ECHO;
        echo_status <= ST_BEYOND;
      end else if (d_in == '0) begin
        cls <= CLS_INORDER;
        echo_status <= ST_DELIVERED;
      end else begin
        cls <= CLS_AHEAD;
        echo_status <= ST_BUFFERED;
      end
    end else if (cmd.mark_step) begin
      mark_cnt  <= mark_cnt + 1'b1;
      mark_slot <= slot_inc(mark_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_in) packet_store[in_slot] <= {in_origin, in_payload};
    if (cmd.read_slot) begin
      rd_word <= packet_store[ne_slot];
      rd_seq  <= next_expected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected    <= '0;
      highest_plus_one <= '0;
      ne_slot          <= '0;
      missing_marks    <= '0;
      run_cnt          <= '0;
    end else begin
      if (cmd.store_in) missing_marks[in_slot] <= 1'b0;
      if (cmd.mark_step) missing_marks[mark_slot] <= 1'b1;
      if (cmd.mark_done) highest_plus_one <= in_seq + 1'b1;
      if (cmd.emit_first && cls == CLS_INORDER) begin
        if (hdist == '0) highest_plus_one <= in_seq + 1'b1;
        next_expected <= ne_plus1;
        ne_slot       <= ne_slot_plus1;
        run_cnt       <= CNT_W'(1);
      end
      if (cmd.read_slot) begin
        next_expected <= ne_plus1;
        ne_slot       <= ne_slot_plus1;
        run_cnt       <= run_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_first) begin
      status      <= echo_status;
      out_seq     <= in_seq;
      out_origin  <= in_origin;
      out_payload <= in_payload;
    end else if (cmd.emit_drain) begin
      status      <= ST_DELIVERED;
      out_seq     <= rd_seq;
      out_origin  <= rd_word[WORD_W-1:PAYLOAD_W];
      out_payload <= rd_word[PAYLOAD_W-1:0];
    end
  end

  always_comb begin
    sts.cls        = cls;
    sts.gap_needed = gap_needed;
    sts.gap_empty  = (mark_cnt >= mark_end);
    sts.mark_last  = (mark_cnt + 1'b1 >= mark_end);
    sts.drain_ok   = (next_expected != highest_plus_one) &&
                     (run_cnt < CNT_W'(WINDOW)) && !missing_marks[ne_slot];
  end

endmodule

// ===== hdl/mrnw_ctrl.sv =====
module mrnw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic              q_full,
  output logic              push,
  output logic              push_last,
  input  mrnw_pkg::dp_sts_t sts,
  output mrnw_pkg::dp_cmd_t cmd
);
  import mrnw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLASS = 7'b0000010,
    S_MARK  = 7'b0000100,
    S_FIRST = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_READ  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    push       = 1'b0;
    push_last  = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.cls == CLS_AHEAD && sts.gap_needed && !sts.gap_empty) begin
          state_next = S_MARK;
        end else begin
          state_next = S_FIRST;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) state_next = S_FIRST;
      end
      S_FIRST: begin
        // in-order and ahead packets write their slot; echoes do not
        cmd.store_in   = (sts.cls != CLS_ECHO);
        cmd.mark_done  = (sts.cls == CLS_AHEAD) && sts.gap_needed;
        cmd.emit_first = 1'b1;
        state_next     = (sts.cls == CLS_INORDER) ? S_CHECK : S_DONE;
      end
      S_CHECK: begin
        // push the held result; flag it last unless a successor drains
        if (!q_full) begin
          push = 1'b1;
          if (sts.drain_ok) begin
            cmd.read_slot = 1'b1;
            state_next    = S_READ;
          end else begin
            push_last  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd.emit_drain = 1'b1;
        state_next     = S_CHECK;
      end
      S_DONE: begin
        if (!q_full) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/mrnw_outq.sv =====
module mrnw_outq #(
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [mrnw_pkg::STATUS_W-1:0]  w_status,
  input  logic [mrnw_pkg::SEQ_W-1:0]     w_seq,
  input  logic [mrnw_pkg::ORIGIN_W-1:0]  w_origin,
  input  logic [mrnw_pkg::PAYLOAD_W-1:0] w_payload,
  input  logic                           w_last,
  output logic                           full,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mrnw_pkg::STATUS_W-1:0]  status,
  output logic [mrnw_pkg::SEQ_W-1:0]     out_seq,
  output logic [mrnw_pkg::ORIGIN_W-1:0]  out_origin,
  output logic [mrnw_pkg::PAYLOAD_W-1:0] out_payload,
  output logic                           last_of_run
);
  import mrnw_pkg::*;

  localparam int EW = STATUS_W + SEQ_W + WORD_W + 1;
  localparam int AW = $clog2(DEPTH);

  logic [EW-1:0]  q [DEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    cnt;
  logic           pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt != '0);
  assign full      = (cnt == (AW+1)'(DEPTH));
  assign {status, out_seq, out_origin, out_payload, last_of_run} = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= {w_status, w_seq, w_origin, w_payload, w_last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) full |-> !push;
  endproperty
  assert property (p_no_overflow) else $error("output queue overflow");

  property p_cnt_bound;
    @(posedge clk) disable iff (rst) cnt <= (AW+1)'(DEPTH);
  endproperty
  assert property (p_cnt_bound) else $error("output queue count out of range");

  property p_pop_moves;
    @(posedge clk) disable iff (rst) (pop && !push) |=> cnt == $past(cnt) - 1'b1;
  endproperty
  assert property (p_pop_moves) else $error("output queue count mismatch");

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrnw_pkg::*;

  localparam int WIN        = WINDOW_DEFAULT;
  localparam int N_RANDOM   = 270;
  localparam int QUIET_FROM = 225;   // from this random item on, no idling on either side
  localparam int STALL_LIMIT = 2000; // cycles without any transfer before giving up

  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [ORIGIN_W-1:0]  origin_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    seq_t                seq;
    origin_t             origin;
    payload_t            payload;
    logic                last;
  } delivery_t;

  // Window tracker: mirrors the receiver's reorder state and holds the
  // deliveries and echoes still owed by the block, oldest first.
  class reorder_scoreboard;
    seq_t              next_exp;
    seq_t              high_p1;
    bit                lost[WIN];
    logic [WORD_W-1:0] slots[WIN];
    delivery_t         owed[$];
    int                errors;

    function new();
      next_exp = '0;
      high_p1  = '0;
      errors   = 0;
      foreach (lost[i]) begin
        lost[i]  = 1'b0;
        slots[i] = '0;
      end
    endfunction

    function void note_packet(seq_t s, origin_t o, payload_t p);
      seq_t      gap;
      seq_t      hspan;
      delivery_t run[$];
      delivery_t r;
      hspan = high_p1 - next_exp;
      r = '{status: ST_BUFFERED, seq: s, origin: o, payload: p, last: 1'b0};
      if (s < next_exp) begin
        r.status = ST_STALE;
        run.push_back(r);
      end else if (s - next_exp >= seq_t'(WIN)) begin
        r.status = ST_BEYOND;
        run.push_back(r);
      end else begin
        gap = s - next_exp;
        slots[s % WIN] = {o, p};
        lost[s % WIN]  = 1'b0;
        if (gap == 0) begin
          // In order: deliver it, then drain buffered successors up to a hole.
          r.status = ST_DELIVERED;
          run.push_back(r);
          if (hspan == 0) high_p1 = s + 1'b1;
          next_exp = next_exp + 1'b1;
          while (next_exp != high_p1 && run.size() < WIN && !lost[next_exp % WIN]) begin
            r.seq     = next_exp;
            r.origin  = slots[next_exp % WIN][WORD_W-1:PAYLOAD_W];
            r.payload = slots[next_exp % WIN][PAYLOAD_W-1:0];
            run.push_back(r);
            next_exp = next_exp + 1'b1;
          end
        end else begin
          // Ahead: mark every skipped sequence above the highest as lost.
          if (gap >= hspan) begin
            for (seq_t i = hspan; i < gap; i++) lost[(next_exp + i) % WIN] = 1'b1;
            high_p1 = s + 1'b1;
          end
          run.push_back(r);
        end
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) owed.push_back(run[i]);
    endfunction

    function void check_result(delivery_t got);
      delivery_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.seq !== want.seq)
        $display("%0t: out_seq expected %0d actual %0d", $time, want.seq, got.seq);
      if (got.origin !== want.origin)
        $display("%0t: out_origin expected %0d actual %0d", $time, want.origin, got.origin);
      if (got.payload !== want.payload)
        $display("%0t: out_payload expected %0d actual %0d", $time, want.payload,
                 got.payload);
      if (got.last !== want.last)
        $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, got.last);
      if (got !== want) errors++;
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     valid = 1'b0;
  logic     stall;
  seq_t     seq_number = '0;
  origin_t  origin_node = '0;
  payload_t payload_value = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  seq_t     out_seq;
  origin_t  out_origin;
  payload_t out_payload;
  logic     last_of_run;

  reorder_scoreboard sb = new();
  bit quiet = 1'b0;     // set near the end: both sides run flat out
  int idle_cycles = 0;

  multicast_reorder_nack_window #(.WINDOW(WIN)) DUT (
    .clk(clk), .rst(rst),
    .valid(valid), .stall(stall),
    .seq_number(seq_number), .origin_node(origin_node), .payload_value(payload_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_seq(out_seq), .out_origin(out_origin),
    .out_payload(out_payload), .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the edge; note the input before checking output.
  always @(posedge clk) begin
    if (!rst) begin
      if (valid && !stall) sb.note_packet(seq_number, origin_node, payload_value);
      if (out_valid && !out_stall)
        sb.check_result('{status: status, seq: out_seq, origin: out_origin,
                          payload: out_payload, last: last_of_run});
      if ((valid && !stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts, with long free stretches too.
  initial begin
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Offer one packet and hold it until the block takes the transfer.
  task automatic send_packet(seq_t s, origin_t o, payload_t p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    valid         <= 1'b1;
    seq_number    <= s;
    origin_node   <= o;
    payload_value <= p;
    do @(posedge clk); while (stall);
  endtask

  task automatic send_rand(seq_t s);
    send_packet(s, origin_t'($urandom), payload_t'($urandom));
  endtask

  // Pick a sequence relative to the window: mostly in-window traffic, with
  // in-order packets often enough that drains keep happening.
  function automatic seq_t pick_seq();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return sb.next_exp;
    if (roll < 75) return sb.next_exp + seq_t'($urandom_range(1, WIN - 1));
    if (roll < 85 && sb.next_exp != 0) return seq_t'($urandom_range(0, sb.next_exp - 1));
    if (roll < 93) return sb.next_exp + seq_t'($urandom_range(WIN, WIN + 8));
    return seq_t'($urandom);
  endfunction

  initial begin
    seq_t base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: in order, gap, fill with drain, stale, duplicate, window edges.
    send_packet(seq_t'(0), '0, '0);
    send_packet(seq_t'(2), '1, '1);                   // marks 1 lost
    send_packet(seq_t'(2), 8'hA5, 20'h5A5A5);         // duplicate overwrites buffered slot
    send_packet(seq_t'(1), 8'h01, 20'h00001);         // fills hole, drains 2
    send_packet(seq_t'(0), 8'h33, 20'h12345);         // stale
    send_packet(seq_t'(3 + WIN), 8'h44, 20'hFFFF0);   // just beyond window
    send_packet(seq_t'(2 + WIN), 8'h55, 20'h0F0F0);   // top of window, marks many lost
    send_packet(seq_t'('1), '1, '1);                  // highest sequence, dropped
    send_packet(seq_t'(3), 8'h66, 20'h11111);         // delivers, stops at a lost mark
    // Fill the rest of the window, then complete it: one long drain.
    base = sb.next_exp;
    for (int i = WIN - 1; i >= 1; i--) send_rand(base + seq_t'(i));
    send_rand(base);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == QUIET_FROM) quiet = 1'b1;
      send_rand(pick_seq());
    end
    valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (2 * WIN + 10) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mrnw_pkg.sv
hdl/mrnw_datapath.sv
hdl/mrnw_ctrl.sv
hdl/mrnw_outq.sv
hdl/multicast_reorder_nack_window.sv
dv/tb.sv
